// ----- rtl/ctsa_pkg.sv -----
// Shared constants and elaboration-time angle table for the cubemap texel
// solid angle block. No dependencies.
package ctsa_pkg;

   localparam int DEF_MAX_FACE_SIZE = 4096;
   localparam int DEF_FRACTION_BITS = 40;

   localparam int FACE_W    = 13;   // face size register width
   localparam int COORD_W   = 12;   // texel index width
   localparam int OUT_W     = 42;   // solid angle result width
   localparam int FACE_RST  = 256;

   localparam int ANG_FRAC     = 60;
   localparam int SQRT_FRAC    = 44;
   localparam int SQRT_STEPS   = 58;
   localparam int CORDIC_STEPS = 58;
   localparam int M_PAIRS      = 14;

   localparam int PQ_W    = 14;   // signed corner numerator
   localparam int MAG_W   = 13;   // corner numerator magnitude
   localparam int SQ_W    = 26;   // squares and product
   localparam int M_W     = 2 * M_PAIRS;   // radicand, one bit pair per root step for the first M_PAIRS steps
   localparam int ROOT_W  = 58;
   localparam int REM_W   = 62;
   localparam int XY_W    = 62;
   localparam int Z_W     = 63;
   localparam int SUM_W   = 64;
   localparam int SHIFT_W = 4;

   // abs/square, sum, sqrt steps, two vector stages, cordic steps, sign fix
   localparam int CORNER_LAT = 2 + SQRT_STEPS + 2 + CORDIC_STEPS + 1;

   // restoring long division for the series terms, quotient only
   function automatic longint unsigned series_div(input longint unsigned num,
                                                  input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) by its Taylor series, 60 fraction bits
   function automatic longint atan_pow2(input int unsigned idx);
      longint acc;
      longint t;
      int unsigned e;
      acc = 0;
      for (int unsigned k = 0; k <= 30; k++) begin
         e = idx * (2 * k + 1);
         if (e <= ANG_FRAC) begin
            t = longint'(series_div(64'd1 << (ANG_FRAC - e), 64'(2 * k + 1)));
            acc = (k[0]) ? acc - t : acc + t;
         end
      end
      return acc;
   endfunction

   // atan(1/3) by its series, 60 fraction bits
   function automatic longint atan_third();
      longint acc;
      longint t;
      longint unsigned pw;
      acc = 0;
      pw  = 64'd3;
      for (int unsigned k = 0; k < 40; k++) begin
         if (pw <= (64'd1 << ANG_FRAC)) begin
            t = longint'(series_div(series_div(64'd1 << ANG_FRAC, pw),
                                    64'(2 * k + 1)));
            acc = (k[0]) ? acc - t : acc + t;
            pw = pw * 64'd9;
         end
      end
      return acc;
   endfunction

   // rotation angle of one vectoring step
   function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
      longint v;
      if (idx == 0) v = atan_pow2(1) + atan_third();
      else          v = atan_pow2(idx);
      return v[Z_W-1:0];
   endfunction

endpackage

// ----- rtl/ctsa_corner.sv -----
// One corner term atan2(a*b, sqrt(a*a+b*b+1)) as a stallable pipeline:
// square root one bit per stage, then CORDIC vectoring one step per stage.
// Depends on ctsa_pkg.
module ctsa_corner (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic signed [ctsa_pkg::PQ_W-1:0]     p_num,
   input  logic signed [ctsa_pkg::PQ_W-1:0]     q_num,
   input  logic        [ctsa_pkg::FACE_W-1:0]   face_n,
   input  logic        [ctsa_pkg::SHIFT_W-1:0]  face_bits,
   output logic signed [ctsa_pkg::Z_W-1:0]      term
);
   import ctsa_pkg::*;

   typedef struct packed {
      logic [ROOT_W-1:0]  root;
      logic [REM_W-1:0]   rem;
      logic [M_W-1:0]     m;
      logic [SQ_W-1:0]    pq;
      logic [FACE_W-1:0]  n;
      logic [SHIFT_W-1:0] s;
      logic               neg;
      logic               zero;
   } sq_stage_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   neg;
      logic                   zero;
   } cd_stage_type;

   // stage 1: magnitudes, squares and product
   logic [MAG_W-1:0]   ap, aq;
   logic [SQ_W-1:0]    sqp_ff, sqq_ff, sqn_ff, pq_ff;
   logic [FACE_W-1:0]  n1_ff;
   logic [SHIFT_W-1:0] s1_ff;
   logic               neg1_ff;

   always_comb begin
      ap = p_num[PQ_W-1] ? MAG_W'(-p_num) : MAG_W'(p_num);
      aq = q_num[PQ_W-1] ? MAG_W'(-q_num) : MAG_W'(q_num);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sqp_ff  <= SQ_W'(ap) * SQ_W'(ap);
         sqq_ff  <= SQ_W'(aq) * SQ_W'(aq);
         sqn_ff  <= SQ_W'(face_n) * SQ_W'(face_n);
         pq_ff   <= SQ_W'(ap) * SQ_W'(aq);
         n1_ff   <= face_n;
         s1_ff   <= face_bits;
         neg1_ff <= p_num[PQ_W-1] ^ q_num[PQ_W-1];
      end
   end

   // stage 2: radicand
   sq_stage_type sq0_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         sq0_ff.root <= '0;
         sq0_ff.rem  <= '0;
         sq0_ff.m    <= M_W'(sqp_ff) + M_W'(sqq_ff) + M_W'(sqn_ff);
         sq0_ff.pq   <= pq_ff;
         sq0_ff.n    <= n1_ff;
         sq0_ff.s    <= s1_ff;
         sq0_ff.neg  <= neg1_ff;
         sq0_ff.zero <= (pq_ff == '0);
      end
   end

   // restoring square root, one result bit per stage
   sq_stage_type sq_ff [1:SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      sq_stage_type src, sq_in;
      logic [REM_W-1:0] rem_sh, trial;
      logic [1:0]       pair;

      if (j == 0) begin : g_first
         assign src = sq0_ff;
      end else begin : g_next
         assign src = sq_ff[j];
      end

      if (j < M_PAIRS) begin : g_pair
         assign pair = src.m[2*(M_PAIRS-1-j) +: 2];
      end else begin : g_nopair
         assign pair = 2'b00;
      end

      always_comb begin
         sq_in  = src;
         rem_sh = {src.rem[REM_W-3:0], pair};
         trial  = {2'b00, src.root, 2'b01};
         if (rem_sh >= trial) begin
            sq_in.rem  = rem_sh - trial;
            sq_in.root = {src.root[ROOT_W-2:0], 1'b1};
         end else begin
            sq_in.rem  = rem_sh;
            sq_in.root = {src.root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) sq_ff[j+1] <= sq_in;
      end
   end

   // vector stage 1: scale root down, place product
   sq_stage_type           vlast;
   logic [ROOT_W-1:0]      rs_ff;
   logic signed [XY_W-1:0] vy_ff;
   logic [FACE_W-1:0]      vn_ff;
   logic                   vneg_ff, vzero_ff;

   assign vlast = sq_ff[SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (enable) begin
         rs_ff    <= vlast.root >> vlast.s;
         vy_ff    <= XY_W'(XY_W'(vlast.pq) << (SQRT_FRAC - int'(vlast.s)));
         vn_ff    <= vlast.n;
         vneg_ff  <= vlast.neg;
         vzero_ff <= vlast.zero;
      end
   end

   // vector stage 2: x = n * scaled root
   cd_stage_type cd0_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         cd0_ff.x    <= XY_W'(vn_ff * rs_ff);
         cd0_ff.y    <= vy_ff;
         cd0_ff.z    <= '0;
         cd0_ff.neg  <= vneg_ff;
         cd0_ff.zero <= vzero_ff;
      end
   end

   // CORDIC vectoring, one micro-rotation per stage
   cd_stage_type cd_ff [1:CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [Z_W-1:0] ANG = atan_entry(i);
      cd_stage_type src, cd_in;
      logic signed [XY_W-1:0] xs, ys;

      if (i == 0) begin : g_first
         assign src = cd0_ff;
      end else begin : g_next
         assign src = cd_ff[i];
      end

      always_comb begin
         // shift on the magnitude, truncating toward zero
         xs = src.x[XY_W-1] ? -((-src.x) >>> i) : (src.x >>> i);
         ys = src.y[XY_W-1] ? -((-src.y) >>> i) : (src.y >>> i);
         cd_in = src;
         if (!src.y[XY_W-1]) begin
            cd_in.x = src.x + ys;
            cd_in.y = src.y - xs;
            cd_in.z = src.z + ANG;
         end else begin
            cd_in.x = src.x - ys;
            cd_in.y = src.y + xs;
            cd_in.z = src.z - ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) cd_ff[i+1] <= cd_in;
      end
   end

   // sign fix, zero product gives zero
   cd_stage_type clast;
   logic signed [Z_W-1:0] term_ff;

   assign clast = cd_ff[CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (enable) begin
         if (clast.zero)     term_ff <= '0;
         else if (clast.neg) term_ff <= -clast.z;
         else                term_ff <= clast.z;
      end
   end

   assign term = term_ff;

endmodule

// ----- rtl/cubemap_texel_solid_angle_top.sv -----
// Top level of the cubemap texel solid angle block: range check, four
// corner pipelines, alternating sum, rounding. Depends on ctsa_pkg, ctsa_corner.
//
// Returns the solid angle of one cubemap texel per request, unsigned with
// FRACTION_BITS fraction bits, saturated to 42 bits. A new request is taken
// every cycle unless a stall on the result side holds the whole pipeline.
// Each request passes the range check, the bit-per-stage square root and
// step-per-stage CORDIC of the corner pipelines, the sum and the rounding.
// A column or row not below the face size, or a face size of zero or above
// MAX_FACE_SIZE, returns zero with out_of_range set.
module cubemap_texel_solid_angle_top #(
   parameter int MAX_FACE_SIZE = ctsa_pkg::DEF_MAX_FACE_SIZE,
   parameter int FRACTION_BITS = ctsa_pkg::DEF_FRACTION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ctsa_pkg::FACE_W-1:0]        csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ctsa_pkg::COORD_W-1:0]       req_texel_col,
   input  logic [ctsa_pkg::COORD_W-1:0]       req_texel_row,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ctsa_pkg::OUT_W-1:0]         rsp_solid_angle,
   output logic                               rsp_out_of_range
);
   import ctsa_pkg::*;

   localparam int SH = ANG_FRAC - FRACTION_BITS;

   logic [FACE_W-1:0] face_size_ff;
   logic              advance;

   // face size register
   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= FACE_W'(FACE_RST);
      end else if (csr_wr_en) begin
         face_size_ff <= csr_wr_data;
      end
   end

   // hold every stage while a result waits
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage 1: range check and corner numerators
   logic                      oor;
   logic [SHIFT_W-1:0]        bits_len;
   logic                      v1_ff, oor1_ff;
   logic signed [PQ_W-1:0]    p0_ff, q0_ff, p1_ff, q1_ff;
   logic [FACE_W-1:0]         n1_ff;
   logic [SHIFT_W-1:0]        s1_ff;
   logic signed [PQ_W-1:0]    p0, q0;

   always_comb begin
      oor = (face_size_ff == '0) || (32'(face_size_ff) > MAX_FACE_SIZE)
         || ({1'b0, req_texel_col} >= face_size_ff)
         || ({1'b0, req_texel_row} >= face_size_ff);
      bits_len = '0;
      for (int b = 0; b < FACE_W; b++) begin
         if (face_size_ff[b]) bits_len = SHIFT_W'(b + 1);
      end
      p0 = PQ_W'({req_texel_col, 1'b0}) - PQ_W'(face_size_ff);
      q0 = PQ_W'({req_texel_row, 1'b0}) - PQ_W'(face_size_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         oor1_ff <= oor;
         p0_ff   <= p0;
         q0_ff   <= q0;
         p1_ff   <= p0 + PQ_W'(2);
         q1_ff   <= q0 + PQ_W'(2);
         n1_ff   <= face_size_ff;
         s1_ff   <= bits_len;
      end
   end

   // four corner terms
   logic signed [Z_W-1:0] t00, t01, t10, t11;

   ctsa_corner u_c00 (.clock, .enable(advance), .p_num(p0_ff), .q_num(q0_ff),
      .face_n(n1_ff), .face_bits(s1_ff), .term(t00));
   ctsa_corner u_c01 (.clock, .enable(advance), .p_num(p0_ff), .q_num(q1_ff),
      .face_n(n1_ff), .face_bits(s1_ff), .term(t01));
   ctsa_corner u_c10 (.clock, .enable(advance), .p_num(p1_ff), .q_num(q0_ff),
      .face_n(n1_ff), .face_bits(s1_ff), .term(t10));
   ctsa_corner u_c11 (.clock, .enable(advance), .p_num(p1_ff), .q_num(q1_ff),
      .face_n(n1_ff), .face_bits(s1_ff), .term(t11));

   // valid and range flag travel alongside the corner pipelines
   logic [CORNER_LAT-1:0] vld_line_ff;
   logic [CORNER_LAT-1:0] oor_line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_line_ff <= '0;
      end else if (advance) begin
         vld_line_ff <= {vld_line_ff[CORNER_LAT-2:0], v1_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) oor_line_ff <= {oor_line_ff[CORNER_LAT-2:0], oor1_ff};
   end

   // alternating sum
   logic                    v2_ff, oor2_ff;
   logic signed [SUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= vld_line_ff[CORNER_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         oor2_ff <= oor_line_ff[CORNER_LAT-1];
         sum_ff  <= SUM_W'(t00) - SUM_W'(t01) - SUM_W'(t10) + SUM_W'(t11);
      end
   end

   // clamp, round half up, saturate
   logic [SUM_W-1:0] rounded;
   logic [OUT_W-1:0] result;

   always_comb begin
      if (sum_ff[SUM_W-1]) begin
         rounded = '0;
      end else begin
         rounded = (SUM_W'(sum_ff) + (SUM_W'(1) << (SH - 1))) >> SH;
      end
      if (rounded[SUM_W-1:OUT_W] != '0) result = '1;
      else                              result = rounded[OUT_W-1:0];
   end

   // output register
   logic [OUT_W-1:0] rsp_solid_angle_ff;
   logic             rsp_out_of_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_out_of_range_ff <= oor2_ff;
         rsp_solid_angle_ff  <= oor2_ff ? '0 : result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_solid_angle  = rsp_solid_angle_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;

endmodule
